// File: rtl/bdc_pkg.sv
// ============================================================================
// bdc_pkg
// Shared types and constants of the de Casteljau Bezier evaluator.
// ============================================================================
package bdc_pkg;

	// Field widths of the item channel and the fraction width of t
	localparam int MODE_W = 2;
	localparam int T_W    = 17;
	localparam int FRAC_W = 16;

	// Depth of the path from a store read to the lerp write-back, also the drain between levels
	localparam int LERP_LAT = 3;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd2;

	// Parameter value for 1.0
	localparam logic [T_W-1:0] T_ONE = 17'd65536;

	// Per-cycle control from the sequencer to each coordinate lane
	typedef struct packed {
		logic pt_we;   // write a control point
		logic rd_en;   // issue a store read
		logic rd_pt;   // read the point store, else the scratch store
		logic lerp;    // the read feeds the lerp chain
		logic first;   // first read of a level, loads the left operand only
	} lane_ctl_t;

	// Result handoff from the sequencer to the output register
	typedef struct packed {
		logic cap;     // result data is ready on the lane read ports
		logic empty;   // point list was empty
	} done_t;

endpackage

// File: rtl/bdc_if.sv
// ============================================================================
// bdc_in_if / bdc_out_if
// Valid/ready channels for input items and evaluated curve points.
// ============================================================================
interface bdc_in_if #(parameter int COORD_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic [bdc_pkg::MODE_W-1:0]    mode;
	logic signed [COORD_WIDTH-1:0] coord_x;
	logic signed [COORD_WIDTH-1:0] coord_y;
	logic signed [COORD_WIDTH-1:0] coord_z;
	logic [bdc_pkg::T_W-1:0]       param_t;

	modport source (output valid, mode, coord_x, coord_y, coord_z, param_t, input ready);
	modport sink (input valid, mode, coord_x, coord_y, coord_z, param_t, output ready);
endinterface

interface bdc_out_if #(parameter int COORD_WIDTH = 32) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] curve_x;
	logic signed [COORD_WIDTH-1:0] curve_y;
	logic signed [COORD_WIDTH-1:0] curve_z;
	logic                          was_empty;

	modport source (output valid, curve_x, curve_y, curve_z, was_empty, input ready);
	modport sink (input valid, curve_x, curve_y, curve_z, was_empty, output ready);
endinterface

// File: rtl/bezier_de_casteljau_eval.sv
// ============================================================================
// bezier_de_casteljau_eval
// Top level: 3D Bezier curve evaluation by de Casteljau reduction.
// ============================================================================
// Items arrive on a valid/ready channel. Append (mode 0) and clear (mode 1)
// leave the block ready for the next item; an append to a full list is
// dropped, mode 3 is ignored. Evaluate (mode 2) with n stored points holds
// ready low while one pipelined lerp unit per coordinate walks the levels
// n-1 down to 1, reading one stored entry per cycle and draining its
// pipeline before each next level; the result is registered once the output
// register is free, without a level walk for an empty list. The result register
// frees the block as soon as it is loaded, so a new item can be taken while
// a result waits downstream.
module bezier_de_casteljau_eval #(
	parameter int MAX_POINTS  = 16,
	parameter int COORD_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	bdc_in_if.sink     item,
	bdc_out_if.source  result
);
	import bdc_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	lane_ctl_t                     ctl;
	done_t                         done;
	logic [AW-1:0]                 pt_waddr;
	logic [AW-1:0]                 rd_addr;
	logic [AW-1:0]                 wr_addr;
	logic [T_W-1:0]                t;
	logic signed [COORD_WIDTH-1:0] rdata_x;
	logic signed [COORD_WIDTH-1:0] rdata_y;
	logic signed [COORD_WIDTH-1:0] rdata_z;
	logic                          out_free;
	logic                          res_vld_q;
	logic signed [COORD_WIDTH-1:0] curve_x_q;
	logic signed [COORD_WIDTH-1:0] curve_y_q;
	logic signed [COORD_WIDTH-1:0] curve_z_q;
	logic                          was_empty_q;

	assign out_free = !res_vld_q || result.ready;

	bdc_seq #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (item.valid),
		.mode     (item.mode),
		.param_t  (item.param_t),
		.out_free (out_free),
		.in_rdy   (item.ready),
		.ctl      (ctl),
		.pt_waddr (pt_waddr),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.t        (t),
		.done     (done)
	);

	bdc_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.MAX_POINTS  (MAX_POINTS),
		.AW          (AW)
	) u_lane_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pt_waddr (pt_waddr),
		.pt_wdata (item.coord_x),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.t        (t),
		.rdata    (rdata_x)
	);

	bdc_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.MAX_POINTS  (MAX_POINTS),
		.AW          (AW)
	) u_lane_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pt_waddr (pt_waddr),
		.pt_wdata (item.coord_y),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.t        (t),
		.rdata    (rdata_y)
	);

	bdc_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.MAX_POINTS  (MAX_POINTS),
		.AW          (AW)
	) u_lane_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pt_waddr (pt_waddr),
		.pt_wdata (item.coord_z),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.t        (t),
		.rdata    (rdata_z)
	);

	// Hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (done.cap && out_free) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	// Load the result payload; an empty list gives zero
	always_ff @(posedge clk) begin
		if (done.cap && out_free) begin
			curve_x_q   <= done.empty ? '0 : rdata_x;
			curve_y_q   <= done.empty ? '0 : rdata_y;
			curve_z_q   <= done.empty ? '0 : rdata_z;
			was_empty_q <= done.empty;
		end
	end

	assign result.valid     = res_vld_q;
	assign result.curve_x   = curve_x_q;
	assign result.curve_y   = curve_y_q;
	assign result.curve_z   = curve_z_q;
	assign result.was_empty = was_empty_q;

endmodule

// File: rtl/bdc_lerp.sv
// ============================================================================
// bdc_lerp
// Pipelined fixed-point lerp: res = a + ((b - a) * t >>> 16), with a tag.
// ============================================================================
module bdc_lerp #(
	parameter int COORD_WIDTH = 32,
	parameter int TAG_W       = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [COORD_WIDTH-1:0] a,
	input  logic signed [COORD_WIDTH-1:0] b,
	input  logic [bdc_pkg::T_W-1:0]       t,
	input  logic [TAG_W-1:0]              in_tag,
	output logic                          out_vld,
	output logic signed [COORD_WIDTH-1:0] res,
	output logic [TAG_W-1:0]              out_tag
);
	import bdc_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = DW + T_W + 1;

	logic                          vld_s1;
	logic                          vld_s2;
	logic signed [DW-1:0]          d_s1;
	logic signed [COORD_WIDTH-1:0] a_s1;
	logic [T_W-1:0]                t_s1;
	logic [TAG_W-1:0]              tag_s1;
	logic signed [PW-1:0]          prod_s2;
	logic signed [COORD_WIDTH-1:0] a_s2;
	logic [TAG_W-1:0]              tag_s2;
	logic signed [PW-1:0]          shifted;
	logic signed [PW-1:0]          sum;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage 1: difference; stage 2: product with t
	always_ff @(posedge clk) begin
		d_s1    <= DW'(b) - DW'(a);
		a_s1    <= a;
		t_s1    <= t;
		tag_s1  <= in_tag;
		prod_s2 <= d_s1 * $signed({1'b0, t_s1});
		a_s2    <= a_s1;
		tag_s2  <= tag_s1;
	end

	// Floor-scale the product and add the left operand; result lies between a and b for t up to 1.0
	assign shifted = prod_s2 >>> FRAC_W;
	assign sum     = PW'(a_s2) + shifted;
	assign res     = sum[COORD_WIDTH-1:0];
	assign out_vld = vld_s2;
	assign out_tag = tag_s2;

endmodule

// File: rtl/bdc_lane.sv
// ============================================================================
// bdc_lane
// One coordinate: point store, scratch store and the lerp unit that reduces
// the scratch list one level at a time.
// ============================================================================
module bdc_lane #(
	parameter int COORD_WIDTH = 32,
	parameter int MAX_POINTS  = 16,
	parameter int AW          = $clog2(MAX_POINTS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bdc_pkg::lane_ctl_t            ctl,
	input  logic [AW-1:0]                 pt_waddr,
	input  logic signed [COORD_WIDTH-1:0] pt_wdata,
	input  logic [AW-1:0]                 rd_addr,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [bdc_pkg::T_W-1:0]       t,
	output logic signed [COORD_WIDTH-1:0] rdata
);
	import bdc_pkg::*;

	logic signed [COORD_WIDTH-1:0] pt_mem [MAX_POINTS];
	logic signed [COORD_WIDTH-1:0] sc_mem [MAX_POINTS];
	logic signed [COORD_WIDTH-1:0] pt_rd_q;
	logic signed [COORD_WIDTH-1:0] sc_rd_q;
	logic signed [COORD_WIDTH-1:0] prev_q;
	logic                          rd_pt_q;
	logic                          tag_vld_q;
	logic                          first_q;
	logic [AW-1:0]                 waddr_q;
	logic                          lerp_vld;
	logic signed [COORD_WIDTH-1:0] lerp_res;
	logic [AW-1:0]                 lerp_addr;

	// Write appended points
	always_ff @(posedge clk) begin
		if (ctl.pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
	end

	// Write lerp results back in place
	always_ff @(posedge clk) begin
		if (lerp_vld) begin
			sc_mem[lerp_addr] <= lerp_res;
		end
	end

	// Registered reads of both stores
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			pt_rd_q <= pt_mem[rd_addr];
			sc_rd_q <= sc_mem[rd_addr];
		end
	end

	// Track what the read data is for
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pt_q   <= 1'b0;
			tag_vld_q <= 1'b0;
			first_q   <= 1'b0;
			waddr_q   <= '0;
		end else begin
			tag_vld_q <= ctl.rd_en & ctl.lerp;
			first_q   <= ctl.first;
			waddr_q   <= wr_addr;
			if (ctl.rd_en) begin
				rd_pt_q <= ctl.rd_pt;
			end
		end
	end

	assign rdata = rd_pt_q ? pt_rd_q : sc_rd_q;

	// Hold the left operand of the next lerp
	always_ff @(posedge clk) begin
		if (tag_vld_q) begin
			prev_q <= rdata;
		end
	end

	bdc_lerp #(
		.COORD_WIDTH (COORD_WIDTH),
		.TAG_W       (AW)
	) u_lerp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (tag_vld_q & ~first_q),
		.a       (prev_q),
		.b       (rdata),
		.t       (t),
		.in_tag  (waddr_q),
		.out_vld (lerp_vld),
		.res     (lerp_res),
		.out_tag (lerp_addr)
	);

endmodule

// File: rtl/bdc_seq.sv
// ============================================================================
// bdc_seq
// Sequencer: keeps the point count, decodes items and walks the levels of
// the de Casteljau reduction, draining the lerp pipeline between levels.
// ============================================================================
module bdc_seq #(
	parameter int MAX_POINTS = 16,
	parameter int AW         = $clog2(MAX_POINTS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [bdc_pkg::MODE_W-1:0] mode,
	input  logic [bdc_pkg::T_W-1:0]    param_t,
	input  logic                       out_free,
	output logic                       in_rdy,
	output bdc_pkg::lane_ctl_t         ctl,
	output logic [AW-1:0]              pt_waddr,
	output logic [AW-1:0]              rd_addr,
	output logic [AW-1:0]              wr_addr,
	output logic [bdc_pkg::T_W-1:0]    t,
	output bdc_pkg::done_t             done
);
	import bdc_pkg::*;

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
	localparam logic [1:0] DRAIN_LAST = 2'(LERP_LAT - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LVL   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FRD   = 3'd3;
	localparam logic [2:0] S_CAP   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [AW-1:0]    lvl_q;
	logic [AW-1:0]    idx_q;
	logic [1:0]       drn_q;
	logic             first_lvl_q;
	logic             empty_q;
	logic [T_W-1:0]   t_q;
	logic             accept;
	logic             room;

	assign in_rdy   = (state_q == S_IDLE);
	assign accept   = in_vld && in_rdy;
	assign room     = (cnt_q < CNT_MAX);
	assign pt_waddr = cnt_q[AW-1:0];
	assign wr_addr  = idx_q - AW'(1);
	assign t        = t_q;
	assign done.cap   = (state_q == S_CAP);
	assign done.empty = empty_q;

	// Drive lane control for the current step
	always_comb begin
		ctl       = '0;
		rd_addr   = idx_q;
		ctl.pt_we = accept && (mode == MODE_APPEND) && room;
		case (state_q)
			S_LVL: begin
				ctl.rd_en = 1'b1;
				ctl.rd_pt = first_lvl_q;
				ctl.lerp  = 1'b1;
				ctl.first = (idx_q == '0);
			end
			S_FRD: begin
				ctl.rd_en = 1'b1;
				ctl.rd_pt = first_lvl_q;
				rd_addr   = '0;
			end
			default: begin
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			lvl_q       <= '0;
			idx_q       <= '0;
			drn_q       <= '0;
			first_lvl_q <= 1'b0;
			empty_q     <= 1'b0;
			t_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_APPEND: begin
								if (room) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							MODE_CLEAR: begin
								cnt_q <= '0;
							end
							MODE_EVAL: begin
								t_q         <= (param_t > T_ONE) ? T_ONE : param_t;
								idx_q       <= '0;
								drn_q       <= '0;
								first_lvl_q <= 1'b1;
								lvl_q       <= AW'(cnt_q - CNT_W'(1));
								if (cnt_q == '0) begin
									empty_q <= 1'b1;
									state_q <= S_CAP;
								end else begin
									empty_q <= 1'b0;
									state_q <= (cnt_q == CNT_W'(1)) ? S_FRD : S_LVL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_LVL: begin
					if (idx_q == lvl_q) begin
						lvl_q   <= lvl_q - AW'(1);
						idx_q   <= '0;
						drn_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_DRAIN: begin
					if (drn_q == DRAIN_LAST) begin
						first_lvl_q <= 1'b0;
						state_q     <= (lvl_q == '0) ? S_FRD : S_LVL;
					end else begin
						drn_q <= drn_q + 2'd1;
					end
				end
				S_FRD: begin
					state_q <= S_CAP;
				end
				S_CAP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Point count never passes capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("point count above capacity");

	// A level walk never runs past its last index and never has level zero
	a_lvl_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LVL) |-> ((idx_q <= lvl_q) && (lvl_q != '0)))
		else $error("level walk out of range");

	// A finished result waits until the output register can take it
	a_cap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CAP) && !out_free) |=> (state_q == S_CAP))
		else $error("result dropped while output busy");

	// Evaluation of an empty list goes straight to the result
	a_empty_path: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == MODE_EVAL) && (cnt_q == '0)) |=> (done.cap && done.empty))
		else $error("empty evaluation not reported");

endmodule
